// ----- rtl/core/rccfd_pkg.sv -----
// rccfd_pkg: shared types and constants of the rc channel frame decoder
// no dependencies; imported by rccfd_state, rccfd_read and rc_channel_frame_decoder_core

package rccfd_pkg;

	localparam logic [1:0]  CMD_FRAME     = 2'd0;
	localparam logic [1:0]  CMD_TICK      = 2'd1;
	localparam logic [1:0]  CMD_READ      = 2'd2;

	localparam logic [10:0] STICK_ID      = 11'h050;
	localparam logic [10:0] STATUS_ID     = 11'h051;
	localparam logic [7:0]  FAILSAFE_MARK = 8'hC3;
	localparam logic [13:0] SILENCE_CAP   = 14'd10000;
	localparam logic [13:0] TIMEOUT_RESET = 14'd100;

	localparam logic [1:0]  POS_NONE      = 2'd0;
	localparam logic [1:0]  POS_UPPER     = 2'd1;
	localparam logic [1:0]  POS_CENTRAL   = 2'd2;
	localparam logic [1:0]  POS_LOWER     = 2'd3;

	// ceil(2^24 / 127), exact for dividends up to 2^17
	localparam logic [17:0] RECIP_127     = 18'd132105;
	localparam int          RECIP_SHIFT   = 24;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [10:0] can_id;
		logic [63:0] payload;
		logic [9:0]  elapsed_ms;
		logic [3:0]  channel;
		logic [24:0] deadband;
	} rccfd_item_t;

	typedef struct packed {
		logic [3:0][15:0] stick;
		logic [1:0][7:0]  volume;
		logic [1:0][7:0]  slide;
		logic [7:0][1:0]  sw;
		logic             fs_flag;
		logic             active;
	} rccfd_view_t;

	typedef struct packed {
		logic signed [25:0] value;
		logic [1:0]         switch_pos;
		logic               failsafe;
		logic               active;
	} rccfd_result_t;

endpackage

// ----- rtl/core/rccfd_state.sv -----
// rccfd_state: channel store, silence timer and timeout register
// depends on rccfd_pkg

module rccfd_state
	import rccfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [13:0] cfg_data,
	input  logic        upd,
	input  rccfd_item_t item,
	output rccfd_view_t view
);

	logic [3:0][15:0] stick_q;
	logic [1:0][7:0]  volume_q;
	logic [1:0][7:0]  slide_q;
	logic [7:0][1:0]  sw_q;
	logic             fs_flag_q;
	logic [13:0]      silence_q;
	logic [13:0]      timeout_q;
	logic [13:0]      silence_tick;
	logic [7:0]       b1;
	logic [7:0]       b2;

	function automatic logic [1:0] decode_switch(input logic [1:0] bits);
		logic [1:0] pos;
		case (bits)
			2'b11:   pos = POS_UPPER;
			2'b10:   pos = POS_CENTRAL;
			default: pos = POS_LOWER;
		endcase
		return pos;
	endfunction

	assign b1 = item.payload[55:48];
	assign b2 = item.payload[47:40];

	assign silence_tick = (silence_q < SILENCE_CAP) ?
		silence_q + {4'd0, item.elapsed_ms} : silence_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_q   <= '0;
			volume_q  <= '0;
			slide_q   <= '0;
			sw_q      <= {8{POS_LOWER}};
			fs_flag_q <= 1'b1;
			silence_q <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (upd) begin
				case (item.cmd)
					CMD_FRAME: begin
						if (item.can_id == STICK_ID) begin
							for (int i = 0; i < 4; i++) begin
								stick_q[i] <= item.payload[63 - 16 * i -: 16];
							end
							silence_q <= '0;
						end else if (item.can_id == STATUS_ID) begin
							fs_flag_q <= (item.payload[63:56] == FAILSAFE_MARK);
							for (int i = 0; i < 4; i++) begin
								sw_q[i]     <= decode_switch(b1[2 * i +: 2]);
								sw_q[i + 4] <= decode_switch(b2[2 * i +: 2]);
							end
							volume_q[0] <= item.payload[39:32];
							volume_q[1] <= item.payload[31:24];
							slide_q[0]  <= item.payload[23:16];
							slide_q[1]  <= item.payload[15:8];
							silence_q   <= '0;
						end
					end
					CMD_TICK: begin
						silence_q <= silence_tick;
						// link lost: sticks back to centre
						if (!(silence_tick < timeout_q)) begin
							stick_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign view.stick   = stick_q;
	assign view.volume  = volume_q;
	assign view.slide   = slide_q;
	assign view.sw      = sw_q;
	assign view.fs_flag = fs_flag_q;
	assign view.active  = (silence_q < timeout_q);

endmodule

// ----- rtl/core/rccfd_read.sv -----
// rccfd_read: channel select and raw/127 scaling to signed Q10.16
// depends on rccfd_pkg

module rccfd_read
	import rccfd_pkg::*;
(
	input  rccfd_item_t   item,
	input  rccfd_view_t   view,
	output rccfd_result_t res
);

	logic [15:0]        raw;
	logic               neg;
	logic [15:0]        mag;
	logic [17:0]        mag4;
	logic [35:0]        prod;
	logic [24:0]        q;
	logic signed [25:0] scaled;
	logic               is_stick;
	logic               is_switch;

	assign is_stick  = (item.channel[3:2] == 2'b00);
	assign is_switch = item.channel[3];

	always_comb begin
		case (item.channel[3:1])
			3'b000, 3'b001: raw = view.stick[item.channel[1:0]];
			3'b010:         raw = {{8{view.volume[item.channel[0]][7]}},
			                       view.volume[item.channel[0]]};
			3'b011:         raw = {{8{view.slide[item.channel[0]][7]}},
			                       view.slide[item.channel[0]]};
			default:        raw = '0;
		endcase
	end

	// 65536 = 516 * 127 + 4, so q = mag * 516 + floor(4 * mag / 127)
	assign neg    = raw[15];
	assign mag    = neg ? (16'd0 - raw) : raw;
	assign mag4   = {mag, 2'b00};
	assign prod   = 36'(mag4) * 36'(RECIP_127);
	assign q      = {mag, 9'd0} + 25'({mag, 2'b00}) + 25'(prod[35:RECIP_SHIFT]);
	assign scaled = neg ? (26'sd0 - $signed({1'b0, q})) : $signed({1'b0, q});

	always_comb begin
		res.switch_pos = POS_NONE;
		res.value      = scaled;
		if (is_switch) begin
			res.value      = '0;
			res.switch_pos = view.sw[item.channel[2:0]];
		end else if (is_stick) begin
			if (!view.active || (q < item.deadband)) begin
				res.value = '0;
			end
		end
		res.failsafe = !view.active || view.fs_flag;
		res.active   = view.active;
	end

endmodule

// ----- rtl/core/rc_channel_frame_decoder_core.sv -----
// rc_channel_frame_decoder_core: item register, state store, read path, result register
// a read beat passes the item register and then the result register to the output
// throughput: one item per cycle while no read is held by a stalled output; the
// state update and read sit between the item register and the result register
// reset: arst_n clears the pipe and channel values; switches go to lower, failsafe set, timeout to 100 ms
// depends on rccfd_pkg, rccfd_state, rccfd_read

module rc_channel_frame_decoder_core
	import rccfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [13:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [10:0]        can_id,
	input  logic [63:0]        payload,
	input  logic [9:0]         elapsed_ms,
	input  logic [3:0]         channel,
	input  logic [24:0]        deadband,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [25:0] value,
	output logic [1:0]         switch_pos,
	output logic               failsafe,
	output logic               active
);

	rccfd_item_t   item_s1;
	logic          valid_s1;
	rccfd_view_t   view;
	rccfd_result_t res;
	rccfd_result_t res_q;
	logic          out_valid_q;
	logic          out_room;
	logic          is_read;
	logic          adv;
	logic          in_fire;

	assign cfg_ready = 1'b1;

	assign is_read  = (item_s1.cmd == CMD_READ);
	assign out_room = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!is_read || out_room);
	assign in_stall = valid_s1 && !adv;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_fire || (valid_s1 && !adv);
			out_valid_q <= (adv && is_read) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.cmd        <= cmd;
			item_s1.can_id     <= can_id;
			item_s1.payload    <= payload;
			item_s1.elapsed_ms <= elapsed_ms;
			item_s1.channel    <= channel;
			item_s1.deadband   <= deadband;
		end
		if (adv && is_read) begin
			res_q <= res;
		end
	end

	rccfd_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.upd      (adv),
		.item     (item_s1),
		.view     (view)
	);

	rccfd_read u_read (
		.item (item_s1),
		.view (view),
		.res  (res)
	);

	assign out_valid  = out_valid_q;
	assign value      = res_q.value;
	assign switch_pos = res_q.switch_pos;
	assign failsafe   = res_q.failsafe;
	assign active     = res_q.active;

endmodule

// ----- rtl/core/rccfd_checker.sv -----
// rccfd_checker: port-level assertions for the rc channel frame decoder
// bound to rc_channel_frame_decoder_core; no package dependency

module rccfd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [25:0] value,
	input logic [1:0]         switch_pos,
	input logic               failsafe,
	input logic               active
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(switch_pos)
			&& $stable(failsafe) && $stable(active))
		else $error("result beat changed while stalled");

	// input backpressure only comes from a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall)
		else $error("input stalled with room at the output");

	a_switch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switch_pos != 2'd0 |-> value == 26'sd0)
		else $error("switch read with non-zero value");

	a_inactive_fs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> failsafe)
		else $error("inactive link without failsafe");

endmodule

bind rc_channel_frame_decoder_core rccfd_checker u_rccfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.value      (value),
	.switch_pos (switch_pos),
	.failsafe   (failsafe),
	.active     (active)
);
